### sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter files.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int HUE_BITS  = 9;
   localparam int SAT_BITS  = 17;
   // quotient bits of the two long divisions
   localparam int SAT_QBITS = 17;
   localparam int HUE_QBITS = 6;

   typedef logic [HUE_BITS-1:0]  hue_type;
   typedef logic [SAT_BITS-1:0]  sat_type;
   typedef logic [HUE_QBITS-1:0] hue_quot_type;
   typedef logic [1:0]           sect_type;

   localparam sect_type SECT_RED   = 2'd0;
   localparam sect_type SECT_GREEN = 2'd1;
   localparam sect_type SECT_BLUE  = 2'd2;

   localparam hue_type HUE_GREEN = 9'd120;
   localparam hue_type HUE_BLUE  = 9'd240;
   localparam hue_type HUE_WRAP  = 9'd360;

   // which channel is largest and the sign of the hue difference
   typedef struct packed {
      sect_type sect;
      logic     neg;
   } hue_ctl_type;

endpackage

### sv/rhc_if.sv
// ----------------------------------------------------------------------------
// rhc_if
// Valid/ready channels of the converter: pixel request and HSV response.
// ----------------------------------------------------------------------------
interface rhc_req_if #(parameter int CHANNEL_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_rsp_if #(parameter int CHANNEL_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [8:0]              hue_degrees;
   logic [16:0]             saturation_frac;
   logic [CHANNEL_BITS-1:0] value_level;

   modport source (output valid, output hue_degrees, output saturation_frac,
                   output value_level, input ready);
   modport sink   (input valid, input hue_degrees, input saturation_frac,
                   input value_level, output ready);
endinterface

### sv/rhc_classify.sv
// ----------------------------------------------------------------------------
// rhc_classify
// Finds the largest and smallest channel, the span between them, the hue
// sector and the magnitude and sign of the sector difference. Registered.
// ----------------------------------------------------------------------------
module rhc_classify
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    valid_in,
   input  logic [CHANNEL_BITS-1:0] red,
   input  logic [CHANNEL_BITS-1:0] green,
   input  logic [CHANNEL_BITS-1:0] blue,
   output logic                    valid_ff,
   output logic [CHANNEL_BITS-1:0] max_ff,
   output logic [CHANNEL_BITS-1:0] span_ff,
   output logic [CHANNEL_BITS-1:0] mag_ff,
   output hue_ctl_type             ctl_ff
);

   logic [CHANNEL_BITS-1:0] max_in;
   logic [CHANNEL_BITS-1:0] min_rg;
   logic [CHANNEL_BITS-1:0] min_val;
   logic [CHANNEL_BITS-1:0] max_rg;
   logic [CHANNEL_BITS-1:0] opa;
   logic [CHANNEL_BITS-1:0] opb;
   logic [CHANNEL_BITS-1:0] span_in;
   logic [CHANNEL_BITS-1:0] mag_in;
   hue_ctl_type             ctl_in;

   always_comb begin
      max_rg  = (green > red) ? green : red;
      max_in  = (blue > max_rg) ? blue : max_rg;
      min_rg  = (green < red) ? green : red;
      min_val = (blue < min_rg) ? blue : min_rg;
      span_in = max_in - min_val;

      // ties go to red, then green
      if (max_in == red) begin
         ctl_in.sect = SECT_RED;
         opa         = green;
         opb         = blue;
      end else if (max_in == green) begin
         ctl_in.sect = SECT_GREEN;
         opa         = blue;
         opb         = red;
      end else begin
         ctl_in.sect = SECT_BLUE;
         opa         = red;
         opb         = green;
      end
      ctl_in.neg = (opa < opb);
      mag_in     = ctl_in.neg ? (opb - opa) : (opa - opb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         max_ff  <= max_in;
         span_ff <= span_in;
         mag_ff  <= mag_in;
         ctl_ff  <= ctl_in;
      end
   end

endmodule

### sv/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rhc_div_step
// One restoring division step: shift in one dividend bit, compare against
// the divisor, subtract on success and give the quotient bit.
// ----------------------------------------------------------------------------
module rhc_div_step #(
   parameter int WIDTH = 8
) (
   input  logic [WIDTH-1:0] rem_in,
   input  logic             bit_in,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] rem_out,
   output logic             quot_bit
);

   logic [WIDTH:0] shifted;
   logic [WIDTH:0] diff;

   always_comb begin
      shifted  = {rem_in, bit_in};
      diff     = shifted - {1'b0, divisor};
      quot_bit = (shifted >= {1'b0, divisor});
      rem_out  = quot_bit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
   end

endmodule

### sv/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Pipelined RGB to HSV converter: value is the largest channel, saturation
// is 65536*span/max and hue is 60*diff/span plus the sector offset, both by
// exact restoring division, one quotient bit per pipeline stage.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    red, green, blue
//   rsp_chan  out  valid/ready    hue_degrees, saturation_frac, value_level
//
// One item per clock while the output register is not stalled. The path
// holds 21 registers: input register, classify, divider setup,
// 17 saturation quotient stages (the 6 hue quotient bits come from the first
// 6 of them), output register.
// Reset clears the valid bits only. When the output register holds an item
// that is not taken, the whole pipeline freezes and req_chan.ready drops.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic     clock,
   input  logic     reset,
   rhc_req_if.sink  req_chan,
   rhc_rsp_if.source rsp_chan
);

   localparam int CB = CHANNEL_BITS;

   logic advance;

   // input register
   logic          in_valid_ff;
   logic [CB-1:0] in_red_ff;
   logic [CB-1:0] in_green_ff;
   logic [CB-1:0] in_blue_ff;

   // classify stage
   logic          cl_valid_ff;
   logic [CB-1:0] cl_max_ff;
   logic [CB-1:0] cl_span_ff;
   logic [CB-1:0] cl_mag_ff;
   hue_ctl_type   cl_ctl_ff;

   // divider pipeline, index = quotient bits done
   logic          dv_valid_ff [0:SAT_QBITS];
   logic [CB-1:0] dv_max_ff   [0:SAT_QBITS];
   hue_ctl_type   dv_ctl_ff   [0:SAT_QBITS];
   logic          dv_gray_ff  [0:SAT_QBITS];
   sat_type       dv_sq_ff    [0:SAT_QBITS];
   hue_quot_type  dv_hq_ff    [0:SAT_QBITS];
   logic [CB-1:0] dv_srem_ff  [0:SAT_QBITS-1];
   logic [CB-1:0] dv_span_ff  [0:HUE_QBITS-1];
   logic [CB-1:0] dv_hrem_ff  [0:HUE_QBITS-1];
   hue_quot_type  dv_hlow_ff  [0:HUE_QBITS-1];
   logic          sat_low_ff;

   // setup values
   logic [CB+5:0]  hue_dividend;

   // output register
   logic          rsp_valid_ff;
   hue_type       rsp_hue_ff;
   sat_type       rsp_sat_ff;
   logic [CB-1:0] rsp_value_ff;
   hue_type       hue_in;
   hue_type       hue_base;
   hue_type       hue_part;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_red_ff   <= req_chan.red;
         in_green_ff <= req_chan.green;
         in_blue_ff  <= req_chan.blue;
      end
   end

   rhc_classify #(
      .CHANNEL_BITS(CB)
   ) u_classify (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .valid_in (in_valid_ff),
      .red      (in_red_ff),
      .green    (in_green_ff),
      .blue     (in_blue_ff),
      .valid_ff (cl_valid_ff),
      .max_ff   (cl_max_ff),
      .span_ff  (cl_span_ff),
      .mag_ff   (cl_mag_ff),
      .ctl_ff   (cl_ctl_ff)
   );

   // 60*mag as 64*mag - 4*mag; its top bits start below span
   assign hue_dividend = {cl_mag_ff, 6'b0} - {4'b0, cl_mag_ff, 2'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= cl_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_max_ff[0]  <= cl_max_ff;
         dv_ctl_ff[0]  <= cl_ctl_ff;
         dv_gray_ff[0] <= (cl_span_ff == '0);
         dv_sq_ff[0]   <= '0;
         dv_hq_ff[0]   <= '0;
         // span << 16 over max: start from span >> 1, shift in span[0]
         dv_srem_ff[0] <= {1'b0, cl_span_ff[CB-1:1]};
         sat_low_ff    <= cl_span_ff[0];
         dv_span_ff[0] <= cl_span_ff;
         dv_hrem_ff[0] <= hue_dividend[CB+5:6];
         dv_hlow_ff[0] <= hue_dividend[5:0];
      end
   end

   for (genvar k = 0; k < SAT_QBITS; k++) begin : g_div
      logic sat_bit_in;
      logic sat_qbit;

      if (k == 0) begin : g_first
         assign sat_bit_in = sat_low_ff;
      end else begin : g_rest
         assign sat_bit_in = 1'b0;
      end

      if (k < SAT_QBITS - 1) begin : g_sat_mid
         logic [CB-1:0] sat_rem;

         rhc_div_step #(
            .WIDTH(CB)
         ) u_sat_step (
            .rem_in   (dv_srem_ff[k]),
            .bit_in   (sat_bit_in),
            .divisor  (dv_max_ff[k]),
            .rem_out  (sat_rem),
            .quot_bit (sat_qbit)
         );

         always_ff @(posedge clock) begin
            if (advance) begin
               dv_srem_ff[k+1] <= sat_rem;
            end
         end
      end else begin : g_sat_last
         rhc_div_step #(
            .WIDTH(CB)
         ) u_sat_step (
            .rem_in   (dv_srem_ff[k]),
            .bit_in   (sat_bit_in),
            .divisor  (dv_max_ff[k]),
            .rem_out  (),
            .quot_bit (sat_qbit)
         );
      end

      if (k < HUE_QBITS - 1) begin : g_hue_mid
         logic [CB-1:0] hue_rem;
         logic          hue_qbit;

         rhc_div_step #(
            .WIDTH(CB)
         ) u_hue_step (
            .rem_in   (dv_hrem_ff[k]),
            .bit_in   (dv_hlow_ff[k][HUE_QBITS-1]),
            .divisor  (dv_span_ff[k]),
            .rem_out  (hue_rem),
            .quot_bit (hue_qbit)
         );

         always_ff @(posedge clock) begin
            if (advance) begin
               dv_hrem_ff[k+1] <= hue_rem;
               dv_hlow_ff[k+1] <= {dv_hlow_ff[k][HUE_QBITS-2:0], 1'b0};
               dv_span_ff[k+1] <= dv_span_ff[k];
               dv_hq_ff[k+1]   <= {dv_hq_ff[k][HUE_QBITS-2:0], hue_qbit};
            end
         end
      end else if (k == HUE_QBITS - 1) begin : g_hue_last
         logic hue_qbit;

         rhc_div_step #(
            .WIDTH(CB)
         ) u_hue_step (
            .rem_in   (dv_hrem_ff[k]),
            .bit_in   (dv_hlow_ff[k][HUE_QBITS-1]),
            .divisor  (dv_span_ff[k]),
            .rem_out  (),
            .quot_bit (hue_qbit)
         );

         always_ff @(posedge clock) begin
            if (advance) begin
               dv_hq_ff[k+1] <= {dv_hq_ff[k][HUE_QBITS-2:0], hue_qbit};
            end
         end
      end else begin : g_hue_done
         always_ff @(posedge clock) begin
            if (advance) begin
               dv_hq_ff[k+1] <= dv_hq_ff[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_max_ff[k+1]  <= dv_max_ff[k];
            dv_ctl_ff[k+1]  <= dv_ctl_ff[k];
            dv_gray_ff[k+1] <= dv_gray_ff[k];
            dv_sq_ff[k+1]   <= {dv_sq_ff[k][SAT_QBITS-2:0], sat_qbit};
         end
      end
   end

   // add the sector offset to the signed quotient
   always_comb begin
      hue_part = dv_ctl_ff[SAT_QBITS].neg
                 ? (hue_type'(0) - hue_type'(dv_hq_ff[SAT_QBITS]))
                 : hue_type'(dv_hq_ff[SAT_QBITS]);
      case (dv_ctl_ff[SAT_QBITS].sect)
         SECT_RED:   hue_base = dv_ctl_ff[SAT_QBITS].neg ? HUE_WRAP : hue_type'(0);
         SECT_GREEN: hue_base = HUE_GREEN;
         SECT_BLUE:  hue_base = HUE_BLUE;
         default:    hue_base = hue_type'(0);
      endcase
      hue_in = dv_gray_ff[SAT_QBITS] ? hue_type'(0) : (hue_base + hue_part);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid_ff[SAT_QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hue_ff   <= hue_in;
         rsp_sat_ff   <= dv_gray_ff[SAT_QBITS] ? sat_type'(0) : dv_sq_ff[SAT_QBITS];
         rsp_value_ff <= dv_max_ff[SAT_QBITS];
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.hue_degrees     = rsp_hue_ff;
   assign rsp_chan.saturation_frac = rsp_sat_ff;
   assign rsp_chan.value_level     = rsp_value_ff;

endmodule

### sv/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input hue_type                 rsp_hue,
   input sat_type                 rsp_sat,
   input logic [CHANNEL_BITS-1:0] rsp_value
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue) && $stable(rsp_sat)
                                  && $stable(rsp_value))
      else $error("rsp item changed while stalled");

   // input backpressure only comes from a blocked result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a blocked rsp item");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue <= HUE_WRAP)
      else $error("hue out of range");

   // zero saturation only for grey pixels, which have zero hue
   a_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sat == '0) |-> rsp_hue == '0)
      else $error("zero saturation with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rhc_checker #(
   .CHANNEL_BITS(CHANNEL_BITS)
) u_rhc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hue   (rsp_chan.hue_degrees),
   .rsp_sat   (rsp_chan.saturation_frac),
   .rsp_value (rsp_chan.value_level)
);
